[hdl/vlpd_pkg.sv]
// vlpd_pkg: field widths and codes shared by the channel interfaces and the peak detector;
// no dependencies

package vlpd_pkg;

    localparam int DATA_W = 32;   // signed q16.16 sample
    localparam int IDX_W  = 15;   // raster index carried in a result
    localparam int DIM_W  = 6;    // width of one dimension register
    localparam int APB_AW = 4;    // four registers at byte addresses 0, 4, 8, 12
    localparam int APB_DW = 32;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_PEAK_MODE = 2'd0,
        REG_DIM_X     = 2'd1,
        REG_DIM_Y     = 2'd2,
        REG_DIM_Z     = 2'd3
    } cfg_reg_t;

    // what an input transaction asks for
    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EMIT = 1'b1
    } action_t;

    // contents of the peak_mode register
    typedef enum logic {
        PEAK_MAXIMA = 1'b0,
        PEAK_MINIMA = 1'b1
    } peak_mode_t;

    // status field of a result
    typedef enum logic {
        STATUS_OK         = 1'b0,
        STATUS_NOT_LOADED = 1'b1
    } status_t;

endpackage

[hdl/vlpd_if.sv]
// vlpd_in_if / vlpd_out_if: valid-ready channels of the volume peak detector
// depends on vlpd_pkg for the payload widths

interface vlpd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic signed [vlpd_pkg::DATA_W-1:0]   sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

interface vlpd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          is_peak;
    logic [vlpd_pkg::IDX_W-1:0]    voxel_index;
    logic                          last;
    logic                          status;

    modport source (output valid, output is_peak, output voxel_index, output last,
                    output status, input ready);
    modport sink   (input valid, input is_peak, input voxel_index, input last,
                    input status, output ready);
endinterface

[hdl/vlpd_ram.sv]
// vlpd_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module vlpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/volume_local_peak_detect_unit.sv]
// Volume local peak detector: samples are loaded in raster order (x fastest, then y,
// then z) into a voxel memory; each emit transaction returns the peak flag of the next
// voxel over its 26-neighbourhood. An emit on a loaded volume reads the centre and then
// the 27 voxels of the 3x3x3 block, one per cycle through the single read port of the
// voxel memory, with setup, drain and result states around the reads. After a dimension
// write the raster position of the next voxel is recovered by a shared restoring divider
// before the first emit, and the input waits while the volume size products settle. An
// emit before the volume is loaded returns status 1. The voxel memory has no clearing pass.
// depends on vlpd_pkg, vlpd_if.sv and vlpd_ram

module volume_local_peak_detect_unit #(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    vlpd_in_if.sink                       in_ch,
    vlpd_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vlpd_pkg::APB_AW-1:0]   paddr,
    input  logic [vlpd_pkg::APB_DW-1:0]   pwdata,
    output logic [vlpd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int DIM_W  = vlpd_pkg::DIM_W;
    localparam int DATA_W = vlpd_pkg::DATA_W;
    localparam int IDX_W  = vlpd_pkg::IDX_W;
    localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SXY_W  = 2 * DIM_W;
    localparam int TOT_W  = 3 * DIM_W;
    localparam int CMP_W  = (CNT_W > TOT_W) ? CNT_W : TOT_W;
    localparam int DIVC_W = (CNT_W > 1) ? $clog2(CNT_W) : 1;
    localparam int CL_W   = 10;   // holds a dimension maximum up to 1023

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DIV1   = 7'b0000010,
        ST_DIV2   = 7'b0000100,
        ST_CENTER = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    // sequencer and configuration
    state_t                     state_reg, state_next;
    logic [1:0]                 settle_reg, settle_next;
    logic                       peak_mode_reg, peak_mode_next;
    logic [DIM_W-1:0]           dim_x_reg, dim_x_next;
    logic [DIM_W-1:0]           dim_y_reg, dim_y_next;
    logic [DIM_W-1:0]           dim_z_reg, dim_z_next;
    logic [SXY_W-1:0]           sxy_reg, sxy_next;
    logic [TOT_W-1:0]           total_reg, total_next;

    // volume counters and raster position of the next voxel
    logic [CNT_W-1:0]           load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]           emit_cnt_reg, emit_cnt_next;
    logic [DIM_W-1:0]           ix_reg, ix_next;
    logic [DIM_W-1:0]           iy_reg, iy_next;
    logic [DIM_W-1:0]           iz_reg, iz_next;
    logic                       coords_valid_reg, coords_valid_next;

    // shared divider
    logic [CNT_W-1:0]           div_num_reg, div_num_next;
    logic [DIM_W-1:0]           div_rem_reg, div_rem_next;
    logic [DIVC_W-1:0]          div_cnt_reg, div_cnt_next;

    // neighbourhood scan
    logic [1:0]                 dxc_reg, dxc_next;
    logic [1:0]                 dyc_reg, dyc_next;
    logic [1:0]                 dzc_reg, dzc_next;
    logic signed [DATA_W-1:0]   ref_val_reg, ref_val_next;
    logic                       peak_reg, peak_next;
    logic                       ref_phase_reg, ref_phase_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic                       res_status_reg, res_status_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic                       out_is_peak_reg, out_is_peak_next;
    logic [IDX_W-1:0]           out_index_reg, out_index_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_status_reg, out_status_next;

    // combinational helpers
    logic [DIM_W-1:0]           sx, sy, sz;
    logic                       cfg_wr;
    vlpd_pkg::cfg_reg_t         cfg_sel;
    logic                       in_fire;
    logic                       loaded;
    logic                       emit_wrap;
    logic                       is_last;
    logic                       slot_free;
    logic [DIM_W:0]             div_trial;
    logic [DIM_W:0]             div_den;
    logic                       div_ge;
    logic [DIM_W-1:0]           div_rem_step;
    logic [CNT_W-1:0]           div_num_step;
    logic                       div_end;
    logic [AW-1:0]              nbr_plus, nbr_minus, nbr_addr;
    logic                       nbr_ok;
    logic                       scan_end;
    logic                       mem_we;
    logic [AW-1:0]              mem_raddr;
    logic [DATA_W-1:0]          mem_rdata;
    logic signed [DATA_W-1:0]   rd_val;
    logic                       beaten;

    // dimensions in use: zero counts as one, above the maximum counts as the maximum
    always_comb
    begin
        sx = (CL_W'(dim_x_reg) > CL_W'(MAX_X)) ? DIM_W'(MAX_X) : dim_x_reg;
        sy = (CL_W'(dim_y_reg) > CL_W'(MAX_Y)) ? DIM_W'(MAX_Y) : dim_y_reg;
        sz = (CL_W'(dim_z_reg) > CL_W'(MAX_Z)) ? DIM_W'(MAX_Z) : dim_z_reg;
        if (dim_x_reg == '0) sx = DIM_W'(1);
        if (dim_y_reg == '0) sy = DIM_W'(1);
        if (dim_z_reg == '0) sz = DIM_W'(1);
    end

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = vlpd_pkg::cfg_reg_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_sel)
            vlpd_pkg::REG_PEAK_MODE:
                prdata = {{(vlpd_pkg::APB_DW-1){1'b0}}, peak_mode_reg};
            vlpd_pkg::REG_DIM_X:
                prdata = {{(vlpd_pkg::APB_DW-DIM_W){1'b0}}, dim_x_reg};
            vlpd_pkg::REG_DIM_Y:
                prdata = {{(vlpd_pkg::APB_DW-DIM_W){1'b0}}, dim_y_reg};
            vlpd_pkg::REG_DIM_Z:
                prdata = {{(vlpd_pkg::APB_DW-DIM_W){1'b0}}, dim_z_reg};
        endcase
    end

    // input is taken only between items and after the size products have settled
    assign in_ch.ready = (state_reg == ST_IDLE) && (settle_reg == 2'd0);
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign loaded    = CMP_W'(load_cnt_reg) >= CMP_W'(total_reg);
    assign emit_wrap = CMP_W'(emit_cnt_reg) >= CMP_W'(total_reg);
    assign is_last   = (CMP_W'(emit_cnt_reg) + CMP_W'(1)) == CMP_W'(total_reg);
    assign slot_free = !out_valid_reg || out_ch.ready;

    // one restoring division step: first idx / sx, then (idx / sx) / sy
    assign div_den      = (state_reg == ST_DIV1) ? {1'b0, sx} : {1'b0, sy};
    assign div_trial    = {div_rem_reg, div_num_reg[CNT_W-1]};
    assign div_ge       = div_trial >= div_den;
    assign div_rem_step = div_ge ? DIM_W'(div_trial - div_den) : DIM_W'(div_trial);
    assign div_num_step = (div_num_reg << 1) | CNT_W'(div_ge);
    assign div_end      = div_cnt_reg == DIVC_W'(CNT_W - 1);

    // neighbour address: idx + dx + dy*sx + dz*sx*sy, with each offset code 0/1/2 as -1/0/+1
    always_comb
    begin
        nbr_plus  = AW'(emit_cnt_reg)
                  + ((dxc_reg == 2'd2) ? AW'(1) : AW'(0))
                  + ((dyc_reg == 2'd2) ? AW'(sx) : AW'(0))
                  + ((dzc_reg == 2'd2) ? AW'(sxy_reg) : AW'(0));
        nbr_minus = ((dxc_reg == 2'd0) ? AW'(1) : AW'(0))
                  + ((dyc_reg == 2'd0) ? AW'(sx) : AW'(0))
                  + ((dzc_reg == 2'd0) ? AW'(sxy_reg) : AW'(0));
        nbr_addr  = nbr_plus - nbr_minus;
    end

    // neighbours beyond a face of the volume are skipped
    assign nbr_ok = !((dxc_reg == 2'd0) && (ix_reg == '0))
                 && !((dxc_reg == 2'd2) && (ix_reg == sx - DIM_W'(1)))
                 && !((dyc_reg == 2'd0) && (iy_reg == '0))
                 && !((dyc_reg == 2'd2) && (iy_reg == sy - DIM_W'(1)))
                 && !((dzc_reg == 2'd0) && (iz_reg == '0))
                 && !((dzc_reg == 2'd2) && (iz_reg == sz - DIM_W'(1)));

    assign scan_end = (dxc_reg == 2'd2) && (dyc_reg == 2'd2) && (dzc_reg == 2'd2);

    assign mem_raddr = (state_reg == ST_CENTER) ? AW'(emit_cnt_reg) : nbr_addr;
    assign rd_val    = mem_rdata;

    // a strictly greater (max mode) or strictly smaller (min mode) neighbour
    assign beaten = (peak_mode_reg == vlpd_pkg::PEAK_MINIMA) ? (rd_val < ref_val_reg)
                                                             : (rd_val > ref_val_reg);

    always_comb
    begin
        state_next        = state_reg;
        settle_next       = (settle_reg != 2'd0) ? settle_reg - 2'd1 : settle_reg;
        peak_mode_next    = peak_mode_reg;
        dim_x_next        = dim_x_reg;
        dim_y_next        = dim_y_reg;
        dim_z_next        = dim_z_reg;
        sxy_next          = SXY_W'(sx) * SXY_W'(sy);
        total_next        = TOT_W'(sxy_reg) * TOT_W'(sz);
        load_cnt_next     = load_cnt_reg;
        emit_cnt_next     = emit_cnt_reg;
        ix_next           = ix_reg;
        iy_next           = iy_reg;
        iz_next           = iz_reg;
        coords_valid_next = coords_valid_reg;
        div_num_next      = div_num_reg;
        div_rem_next      = div_rem_reg;
        div_cnt_next      = div_cnt_reg;
        dxc_next          = dxc_reg;
        dyc_next          = dyc_reg;
        dzc_next          = dzc_reg;
        ref_val_next      = ref_val_reg;
        peak_next         = peak_reg;
        ref_phase_next    = ref_phase_reg;
        pend_valid_next   = pend_valid_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg;
        out_is_peak_next  = out_is_peak_reg;
        out_index_next    = out_index_reg;
        out_last_next     = out_last_reg;
        out_status_next   = out_status_reg;
        mem_we            = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        // first compare stage: the first word back is the centre, the rest are neighbours
        if ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
        begin
            if (ref_phase_reg)
            begin
                ref_val_next   = rd_val;
                peak_next      = rd_val != '0;
                ref_phase_next = 1'b0;
            end
            else if (pend_valid_reg && beaten)
            begin
                peak_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.action == vlpd_pkg::ACT_LOAD)
                    begin
                        // loads past the volume end are dropped
                        if (!loaded)
                        begin
                            mem_we        = 1'b1;
                            load_cnt_next = load_cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (!loaded)
                    begin
                        res_status_next = vlpd_pkg::STATUS_NOT_LOADED;
                        state_next      = ST_FINISH;
                    end
                    else
                    begin
                        res_status_next = vlpd_pkg::STATUS_OK;
                        div_num_next    = emit_cnt_reg;
                        div_rem_next    = '0;
                        div_cnt_next    = '0;
                        if (emit_wrap)
                        begin
                            // volume shrank under the emit counter: restart at voxel 0
                            emit_cnt_next     = '0;
                            ix_next           = '0;
                            iy_next           = '0;
                            iz_next           = '0;
                            coords_valid_next = 1'b1;
                            state_next        = ST_CENTER;
                        end
                        else if (!coords_valid_reg)
                        begin
                            state_next = ST_DIV1;
                        end
                        else
                        begin
                            state_next = ST_CENTER;
                        end
                    end
                end
            end

            ST_DIV1:
            begin
                div_num_next = div_num_step;
                div_rem_next = div_rem_step;
                div_cnt_next = div_cnt_reg + DIVC_W'(1);
                if (div_end)
                begin
                    ix_next      = div_rem_step;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV2;
                end
            end

            ST_DIV2:
            begin
                div_num_next = div_num_step;
                div_rem_next = div_rem_step;
                div_cnt_next = div_cnt_reg + DIVC_W'(1);
                if (div_end)
                begin
                    iy_next           = div_rem_step;
                    iz_next           = DIM_W'(div_num_step);
                    coords_valid_next = 1'b1;
                    state_next        = ST_CENTER;
                end
            end

            ST_CENTER:
            begin
                // centre read goes out this cycle
                ref_phase_next  = 1'b1;
                pend_valid_next = 1'b0;
                dxc_next        = 2'd0;
                dyc_next        = 2'd0;
                dzc_next        = 2'd0;
                state_next      = ST_SCAN;
            end

            ST_SCAN:
            begin
                // the block's own centre is read once more; it never beats itself
                pend_valid_next = nbr_ok;
                if (dxc_reg == 2'd2)
                begin
                    dxc_next = 2'd0;
                    if (dyc_reg == 2'd2)
                    begin
                        dyc_next = 2'd0;
                        dzc_next = dzc_reg + 2'd1;
                    end
                    else
                    begin
                        dyc_next = dyc_reg + 2'd1;
                    end
                end
                else
                begin
                    dxc_next = dxc_reg + 2'd1;
                end
                if (scan_end)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (res_status_reg == vlpd_pkg::STATUS_NOT_LOADED)
                    begin
                        out_is_peak_next = 1'b0;
                        out_index_next   = '0;
                        out_last_next    = 1'b0;
                        out_status_next  = vlpd_pkg::STATUS_NOT_LOADED;
                    end
                    else
                    begin
                        out_is_peak_next = peak_reg;
                        out_index_next   = IDX_W'(emit_cnt_reg);
                        out_last_next    = is_last;
                        out_status_next  = vlpd_pkg::STATUS_OK;
                        if (is_last)
                        begin
                            // whole volume reported: ready for a fresh load
                            load_cnt_next     = '0;
                            emit_cnt_next     = '0;
                            ix_next           = '0;
                            iy_next           = '0;
                            iz_next           = '0;
                            coords_valid_next = 1'b1;
                        end
                        else
                        begin
                            emit_cnt_next = emit_cnt_reg + CNT_W'(1);
                            if (ix_reg == sx - DIM_W'(1))
                            begin
                                ix_next = '0;
                                if (iy_reg == sy - DIM_W'(1))
                                begin
                                    iy_next = '0;
                                    iz_next = iz_reg + DIM_W'(1);
                                end
                                else
                                begin
                                    iy_next = iy_reg + DIM_W'(1);
                                end
                            end
                            else
                            begin
                                ix_next = ix_reg + DIM_W'(1);
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // the user must write registers only while idle; the block itself does not enforce this
        if (cfg_wr)
        begin
            unique case (cfg_sel)
                vlpd_pkg::REG_PEAK_MODE: peak_mode_next = pwdata[0];
                vlpd_pkg::REG_DIM_X:     dim_x_next     = pwdata[DIM_W-1:0];
                vlpd_pkg::REG_DIM_Y:     dim_y_next     = pwdata[DIM_W-1:0];
                vlpd_pkg::REG_DIM_Z:     dim_z_next     = pwdata[DIM_W-1:0];
            endcase
            if (cfg_sel != vlpd_pkg::REG_PEAK_MODE)
            begin
                // raster position must be recomputed and the size products rebuilt
                coords_valid_next = 1'b0;
                settle_next       = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            settle_reg       <= 2'd2;
            peak_mode_reg    <= vlpd_pkg::PEAK_MAXIMA;
            dim_x_reg        <= DIM_W'(32);
            dim_y_reg        <= DIM_W'(32);
            dim_z_reg        <= DIM_W'(32);
            load_cnt_reg     <= '0;
            emit_cnt_reg     <= '0;
            ix_reg           <= '0;
            iy_reg           <= '0;
            iz_reg           <= '0;
            coords_valid_reg <= 1'b1;
            div_cnt_reg      <= '0;
            dxc_reg          <= 2'd0;
            dyc_reg          <= 2'd0;
            dzc_reg          <= 2'd0;
            ref_phase_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
            res_status_reg   <= vlpd_pkg::STATUS_OK;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            settle_reg       <= settle_next;
            peak_mode_reg    <= peak_mode_next;
            dim_x_reg        <= dim_x_next;
            dim_y_reg        <= dim_y_next;
            dim_z_reg        <= dim_z_next;
            load_cnt_reg     <= load_cnt_next;
            emit_cnt_reg     <= emit_cnt_next;
            ix_reg           <= ix_next;
            iy_reg           <= iy_next;
            iz_reg           <= iz_next;
            coords_valid_reg <= coords_valid_next;
            div_cnt_reg      <= div_cnt_next;
            dxc_reg          <= dxc_next;
            dyc_reg          <= dyc_next;
            dzc_reg          <= dzc_next;
            ref_phase_reg    <= ref_phase_next;
            pend_valid_reg   <= pend_valid_next;
            res_status_reg   <= res_status_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload and derived registers, no reset
    always_ff @(posedge clk)
    begin
        sxy_reg         <= sxy_next;
        total_reg       <= total_next;
        div_num_reg     <= div_num_next;
        div_rem_reg     <= div_rem_next;
        ref_val_reg     <= ref_val_next;
        peak_reg        <= peak_next;
        out_is_peak_reg <= out_is_peak_next;
        out_index_reg   <= out_index_next;
        out_last_reg    <= out_last_next;
        out_status_reg  <= out_status_next;
    end

    vlpd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_voxel_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(load_cnt_reg)),
        .wdata (in_ch.sample),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.is_peak     = out_is_peak_reg;
    assign out_ch.voxel_index = out_index_reg;
    assign out_ch.last        = out_last_reg;
    assign out_ch.status      = out_status_reg;

endmodule
